// ----- rtl/core/mqra_pkg.sv -----
// Shared types and constants for the message queue ring allocator.
package mqra_pkg;

    localparam int QUEUE_DEPTH  = 16;
    localparam int BUFFER_BYTES = 1024;

    localparam int QIDX_W   = $clog2(QUEUE_DEPTH);
    localparam int PTR_W    = $clog2(BUFFER_BYTES + 1);
    localparam int SUM_W    = PTR_W + 2;
    localparam int ID_W     = 8;
    localparam int SIZE_W   = 11;

    typedef enum logic [1:0] {
        MODE_SEND  = 2'd0,
        MODE_RUN   = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_QUEUED    = 3'd0,
        ST_NO_TARGET = 3'd1,
        ST_NO_SPACE  = 3'd2,
        ST_FULL      = 3'd3,
        ST_DEQUEUED  = 3'd4,
        ST_EMPTY     = 3'd5,
        ST_CLEARED   = 3'd6
    } status_t;

    typedef struct packed {
        mode_t             mode;
        logic [ID_W-1:0]   msg_target;
        logic [ID_W-1:0]   msg_type;
        logic [SIZE_W-1:0] msg_size;
    } in_item_t;

    typedef struct packed {
        status_t           status;
        logic [ID_W-1:0]   out_target;
        logic [ID_W-1:0]   out_type;
        logic [SIZE_W-1:0] out_size;
        logic [SIZE_W-1:0] out_offset;
    } out_item_t;

    typedef struct packed {
        logic [ID_W-1:0]   target;
        logic [ID_W-1:0]   kind;
        logic [SIZE_W-1:0] size;
        logic [SIZE_W-1:0] offset;
    } desc_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic execute;
    } ctl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_busy;
    } dp_stat_t;

endpackage

// ----- rtl/core/message_queue_ring_allocator.sv -----
// Top level: message descriptor queue with a ring allocator for payload space.
// Flow: an accepted item is held in the request register; its result is registered into the
//   output register (out_valid high) once that register is free; a stalled output delays execution.
// The accept/execute controller stalls the input until the current item executes, so a new
//   item is not taken before the last one has executed.
// Reset: asynchronous, active low; clears queue and ring pointers and the output valid.
//   Descriptor memory contents are not cleared.
module message_queue_ring_allocator
    import mqra_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    ctl_cmd_t cmd;
    dp_stat_t stat;

    // Controller: hold the input stalled while one item is in execution
    mqra_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath: check queue and ring space, update pointers, drive the result item
    mqra_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

// ----- rtl/core/mqra_ctrl.sv -----
// Controller state machine: accept a request, then execute it once the output is free.
module mqra_ctrl
    import mqra_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  dp_stat_t stat,
    output ctl_cmd_t cmd
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } ctrl_state_t;

    ctrl_state_t state_reg;
    logic        in_stall_reg;

    always_comb
    begin
        cmd.capture = in_valid && !in_stall_reg;
        cmd.execute = (state_reg == S_EXEC) && !stat.out_busy;
    end

    assign in_stall = in_stall_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            in_stall_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd.capture)
                    begin
                        state_reg    <= S_EXEC;
                        in_stall_reg <= 1'b1;
                    end
                end
                S_EXEC:
                begin
                    if (cmd.execute)
                    begin
                        state_reg    <= S_IDLE;
                        in_stall_reg <= 1'b0;
                    end
                end
                default:
                begin
                    state_reg    <= S_IDLE;
                    in_stall_reg <= 1'b0;
                end
            endcase
        end
    end

endmodule

// ----- rtl/core/mqra_datapath.sv -----
// Datapath: queue pointers, ring space pointers, descriptor memory and output register.
module mqra_datapath
    import mqra_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  in_item_t  in_data,
    input  ctl_cmd_t  cmd,
    output dp_stat_t  stat,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    in_item_t          req_reg;
    logic [QIDX_W-1:0] head_reg, head_next;
    logic [QIDX_W-1:0] tail_reg, tail_next;
    logic [PTR_W-1:0]  start_reg, start_next;
    logic [PTR_W-1:0]  end_reg, end_next;
    desc_t             mem [QUEUE_DEPTH];
    desc_t             rd_data_reg;
    out_item_t         out_reg, out_next;
    logic              out_valid_reg;
    logic              has_result;
    logic              wr_en;
    desc_t             wr_desc;

    logic [QIDX_W-1:0] tail_inc, head_inc;
    logic              q_full, q_empty;
    logic [SUM_W-1:0]  sz_x, start_x, end_x, room_x, sum_x;
    logic              fit;
    logic [PTR_W-1:0]  alloc_off, alloc_end;

    assign stat.out_busy = out_valid_reg && out_stall;
    assign out_valid     = out_valid_reg;
    assign out_data      = out_reg;

    always_comb
    begin
        tail_inc = (tail_reg == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
        head_inc = (head_reg == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
        q_full   = (tail_inc == head_reg);
        q_empty  = (head_reg == tail_reg);
    end

    // Ring allocation: append after end, wrap to zero, or fit in the gap.
    always_comb
    begin
        sz_x      = SUM_W'(req_reg.msg_size);
        start_x   = SUM_W'(start_reg);
        end_x     = SUM_W'(end_reg);
        room_x    = SUM_W'(BUFFER_BYTES) - end_x;
        sum_x     = end_x + sz_x;
        fit       = 1'b0;
        alloc_off = end_reg;
        alloc_end = end_reg;
        if (start_x <= end_x)
        begin
            if (room_x >= sz_x)
            begin
                fit       = 1'b1;
                alloc_end = PTR_W'(sum_x);
            end
            else if (start_x > sz_x)
            begin
                fit       = 1'b1;
                alloc_off = '0;
                alloc_end = PTR_W'(sz_x);
            end
        end
        else if (sum_x < start_x)
        begin
            fit       = 1'b1;
            alloc_end = PTR_W'(sum_x);
        end
    end

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        start_next = start_reg;
        end_next   = end_reg;
        out_next   = '0;
        has_result = 1'b1;
        wr_en      = 1'b0;
        wr_desc.target = req_reg.msg_target;
        wr_desc.kind   = req_reg.msg_type;
        wr_desc.size   = req_reg.msg_size;
        wr_desc.offset = SIZE_W'(alloc_off);
        unique case (req_reg.mode)
            MODE_SEND:
            begin
                priority if (req_reg.msg_target == '0)
                    out_next.status = ST_NO_TARGET;
                else if (q_full)
                    out_next.status = ST_FULL;
                else if (!fit)
                    out_next.status = ST_NO_SPACE;
                else
                begin
                    out_next.status     = ST_QUEUED;
                    out_next.out_offset = SIZE_W'(alloc_off);
                    wr_en               = 1'b1;
                    tail_next           = tail_inc;
                    end_next            = alloc_end;
                end
            end
            MODE_RUN:
            begin
                if (q_empty)
                    out_next.status = ST_EMPTY;
                else
                begin
                    out_next.status     = ST_DEQUEUED;
                    out_next.out_target = rd_data_reg.target;
                    out_next.out_type   = rd_data_reg.kind;
                    out_next.out_size   = rd_data_reg.size;
                    out_next.out_offset = rd_data_reg.offset;
                    head_next           = head_inc;
                    start_next          = PTR_W'(SUM_W'(rd_data_reg.offset)
                                                 + SUM_W'(rd_data_reg.size));
                end
            end
            MODE_CLEAR:
            begin
                out_next.status = ST_CLEARED;
                head_next       = '0;
                tail_next       = '0;
            end
            MODE_NONE:
                has_result = 1'b0;
            default:
                has_result = 1'b0;
        endcase
    end

    // Descriptor memory: write on a queued send, read the head every cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.execute && wr_en)
            mem[tail_reg] <= wr_desc;
        rd_data_reg <= mem[head_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            req_reg <= in_data;
        if (cmd.execute && has_result)
            out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            start_reg     <= '0;
            end_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.execute)
            begin
                head_reg  <= head_next;
                tail_reg  <= tail_next;
                start_reg <= start_next;
                end_reg   <= end_next;
            end
            if (cmd.execute && has_result)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.execute && out_valid_reg && out_stall))
        else $error("result produced while output register still held");

    a_queue_not_empty_after_send: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.execute && wr_en) |=> (head_reg != tail_reg))
        else $error("queue empty right after a queued send");

    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (SUM_W'(end_reg) <= SUM_W'(BUFFER_BYTES)) && (SUM_W'(start_reg) <= SUM_W'(BUFFER_BYTES)))
        else $error("ring pointer beyond buffer size");

endmodule
